FILE: hw/rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared constants and types for the sliding window median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

   // default sizes for the top-level parameters
   localparam int MAX_WIDTH_DEF   = 15;
   localparam int SAMPLE_BITS_DEF = 32;

   // fixed field widths of the channels
   localparam int SAMPLE_FIELD_BITS = 32;
   localparam int TAG_BITS          = 8;
   localparam int SLOT_FIELD_BITS   = 4;
   localparam int CSR_BITS          = 4;

   // packed channel widths, rounded up to whole bytes
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 48;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - SAMPLE_FIELD_BITS - SLOT_FIELD_BITS - TAG_BITS;

   // window width after reset
   localparam logic [CSR_BITS-1:0] WIDTH_RESET = 4'd5;

   // result queue between the ranking network and the output side
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   // one result transaction
   typedef struct packed {
      logic [TAG_BITS-1:0]          median_tag;
      logic [SLOT_FIELD_BITS-1:0]   median_slot;
      logic [SAMPLE_FIELD_BITS-1:0] median_value;
   } result_type;

   // queue fill status seen by the front
   typedef struct packed {
      logic                     empty;
      logic [FIFO_CNT_BITS-1:0] count;
   } fifo_status_type;

endpackage

FILE: hw/rtl/smf_window.sv
// ----------------------------------------------------------------------------
// smf_window
// Front end: accepts sample transactions, holds the circular window, the
// write pointer and the width register.
// ----------------------------------------------------------------------------
module smf_window #(
   parameter int MAX_WIDTH   = smf_pkg::MAX_WIDTH_DEF,
   parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF,
   localparam int PTR_BITS   = $clog2(MAX_WIDTH),
   localparam int WBITS      = $clog2(MAX_WIDTH + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [smf_pkg::CSR_BITS-1:0]           csr_wdata,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [smf_pkg::SAMPLE_FIELD_BITS-1:0]  in_sample,
   input  logic [smf_pkg::TAG_BITS-1:0]           in_tag,
   input  logic                                   credit_ok,
   output logic                                   issue,
   output logic [SAMPLE_BITS-1:0]                 samples [MAX_WIDTH],
   output logic [smf_pkg::TAG_BITS-1:0]           tags [MAX_WIDTH],
   output logic [WBITS-1:0]                       width_eff
);

   localparam int EXT_BITS = (WBITS > smf_pkg::CSR_BITS) ? WBITS : smf_pkg::CSR_BITS;
   localparam logic [EXT_BITS-1:0] MAX_EXT = EXT_BITS'(MAX_WIDTH);
   localparam logic [EXT_BITS-1:0] MAX_ODD = (MAX_WIDTH % 2 == 1) ?
                                             EXT_BITS'(MAX_WIDTH) : EXT_BITS'(MAX_WIDTH - 1);

   logic [smf_pkg::CSR_BITS-1:0] width_ff;
   logic [PTR_BITS-1:0]          ptr_ff, ptr_in;
   logic                         issue_ff;
   logic [SAMPLE_BITS-1:0]       samples_ff [MAX_WIDTH];
   logic [smf_pkg::TAG_BITS-1:0] tags_ff [MAX_WIDTH];
   logic [EXT_BITS-1:0]          width_odd;
   logic [WBITS-1:0]             slot_w, slot_next;
   logic [PTR_BITS-1:0]          slot;
   logic                         accept;

   // odd width, saturated to the window size
   always_comb begin
      width_odd = EXT_BITS'(width_ff) | EXT_BITS'(1);
      if (width_odd > MAX_EXT) begin
         width_odd = MAX_ODD;
      end
   end
   assign width_eff = WBITS'(width_odd);

   // slot to write and pointer advance
   always_comb begin
      slot_w = (WBITS'(ptr_ff) < width_eff) ? WBITS'(ptr_ff) : '0;
      slot   = PTR_BITS'(slot_w);
      slot_next = slot_w + WBITS'(1);
      ptr_in = (slot_next >= width_eff) ? '0 : PTR_BITS'(slot_next);
   end

   assign in_ready = credit_ok;
   assign accept   = in_valid && credit_ok;
   assign issue    = issue_ff;
   assign samples  = samples_ff;
   assign tags     = tags_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= smf_pkg::WIDTH_RESET;
         ptr_ff   <= '0;
         issue_ff <= 1'b0;
      end else begin
         issue_ff <= accept;
         if (csr_we) begin
            width_ff <= csr_wdata;
            ptr_ff   <= '0;
         end else if (accept) begin
            ptr_ff <= ptr_in;
         end
      end
   end

   // window storage, cleared at reset
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_WIDTH; k++) begin
         if (reset) begin
            samples_ff[k] <= '0;
            tags_ff[k]    <= '0;
         end else if (accept && (slot == PTR_BITS'(k))) begin
            samples_ff[k] <= SAMPLE_BITS'(in_sample);
            tags_ff[k]    <= in_tag;
         end
      end
   end

endmodule

FILE: hw/rtl/smf_rank.sv
// ----------------------------------------------------------------------------
// smf_rank
// Back end: pairwise comparator network over the window, rank count per
// slot and selection of the slot holding the middle rank.
// ----------------------------------------------------------------------------
module smf_rank #(
   parameter int MAX_WIDTH   = smf_pkg::MAX_WIDTH_DEF,
   parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF,
   localparam int PTR_BITS   = $clog2(MAX_WIDTH),
   localparam int WBITS      = $clog2(MAX_WIDTH + 1)
) (
   input  logic [SAMPLE_BITS-1:0]       samples [MAX_WIDTH],
   input  logic [smf_pkg::TAG_BITS-1:0] tags [MAX_WIDTH],
   input  logic [WBITS-1:0]             width_eff,
   output smf_pkg::result_type          result
);

   logic [MAX_WIDTH-1:0] beats [MAX_WIDTH];
   logic [WBITS-1:0]     rank [MAX_WIDTH];
   logic [WBITS-1:0]     mid;
   logic [PTR_BITS-1:0]  found;

   // pairwise compare; ties go to the lower slot
   always_comb begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         for (int j = 0; j < MAX_WIDTH; j++) begin
            if ((WBITS'(i) >= width_eff) || (WBITS'(j) >= width_eff) || (i == j)) begin
               beats[i][j] = 1'b0;
            end else if (j < i) begin
               beats[i][j] = $signed(samples[i]) > $signed(samples[j]);
            end else begin
               beats[i][j] = $signed(samples[i]) >= $signed(samples[j]);
            end
         end
      end
   end

   // rank of each slot
   always_comb begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         rank[i] = WBITS'($countones(beats[i]));
      end
   end

   // lowest slot with the middle rank
   always_comb begin
      mid   = width_eff >> 1;
      found = '0;
      for (int i = MAX_WIDTH - 1; i >= 0; i--) begin
         if ((WBITS'(i) < width_eff) && (rank[i] == mid)) begin
            found = PTR_BITS'(i);
         end
      end
   end

   assign result.median_value = smf_pkg::SAMPLE_FIELD_BITS'(samples[found]);
   assign result.median_slot  = smf_pkg::SLOT_FIELD_BITS'(found);
   assign result.median_tag   = tags[found];

endmodule

FILE: hw/rtl/smf_fifo.sv
// ----------------------------------------------------------------------------
// smf_fifo
// Short result queue between the ranking network and the response channel.
// ----------------------------------------------------------------------------
module smf_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  smf_pkg::result_type      push_data,
   input  logic                     pop,
   output smf_pkg::result_type      head,
   output smf_pkg::fifo_status_type status
);

   smf_pkg::result_type                  mem_ff [smf_pkg::FIFO_DEPTH];
   logic [smf_pkg::FIFO_PTR_BITS-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [smf_pkg::FIFO_CNT_BITS-1:0]    count_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + smf_pkg::FIFO_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + smf_pkg::FIFO_PTR_BITS'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + smf_pkg::FIFO_CNT_BITS'(1);
            2'b01:   count_ff <= count_ff - smf_pkg::FIFO_CNT_BITS'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);

endmodule

FILE: hw/rtl/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median over a circular window of odd width, with slot and tag of
// the median sample.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  req_     | in        | req_tvalid/req_tready | tdata: sample[31:0], tag[39:32]
//  rsp_     | out       | rsp_tvalid/rsp_tready | tdata: value[31:0], slot[35:32],
//           |           |                       |        tag[43:36], zero[47:44]
//  csr_     | in        | csr_we                | csr_wdata: window_width[3:0]
//
// one transaction per cycle while the result queue has credit; each request
// passes the window write, then the comparator network into the result queue.
// req_tready drops only when the four-entry result queue plus the transaction
// in the ranking stage would overflow, i.e. after rsp_tready was held low.
// synchronous reset clears the window to zero, the pointer to zero and the
// width to five; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_window_median #(
   parameter int MAX_WIDTH   = smf_pkg::MAX_WIDTH_DEF,
   parameter int SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // window_width[3:0]
   input  logic                              csr_we,
   input  logic [smf_pkg::CSR_BITS-1:0]      csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sample[31:0], tag[39:32]
   input  logic [smf_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // median_value[31:0], median_slot[35:32], median_tag[43:36], zero[47:44]
   output logic [smf_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int WBITS = $clog2(MAX_WIDTH + 1);

   logic                            credit_ok;
   logic                            issue;
   logic [SAMPLE_BITS-1:0]          samples [MAX_WIDTH];
   logic [smf_pkg::TAG_BITS-1:0]    tags [MAX_WIDTH];
   logic [WBITS-1:0]                width_eff;
   smf_pkg::result_type             result;
   smf_pkg::result_type             head;
   smf_pkg::fifo_status_type        status;
   logic                            pop;

   // credit: queue entries plus the transaction being ranked
   assign credit_ok = (smf_pkg::FIFO_CNT_BITS'(status.count + smf_pkg::FIFO_CNT_BITS'(issue))
                       < smf_pkg::FIFO_CNT_BITS'(smf_pkg::FIFO_DEPTH));

   // front: accept and window write
   smf_window #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sample (req_tdata[smf_pkg::SAMPLE_FIELD_BITS-1:0]),
      .in_tag    (req_tdata[smf_pkg::SAMPLE_FIELD_BITS +: smf_pkg::TAG_BITS]),
      .credit_ok (credit_ok),
      .issue     (issue),
      .samples   (samples),
      .tags      (tags),
      .width_eff (width_eff)
   );

   // back: ranking network
   smf_rank #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_rank (
      .samples   (samples),
      .tags      (tags),
      .width_eff (width_eff),
      .result    (result)
   );

   // result queue
   smf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (issue),
      .push_data (result),
      .pop       (pop),
      .head      (head),
      .status    (status)
   );

   // response channel
   assign rsp_tvalid = !status.empty;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {{smf_pkg::RSP_PAD_BITS{1'b0}}, head.median_tag,
                        head.median_slot, head.median_value};

`ifndef ASSERT_OFF
   // an accepted request is ranked in the next cycle
   a_accept_issue: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> issue)
      else $error("accepted request not ranked");

   // the credit check keeps a slot free for every ranked transaction
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      issue |-> (status.count < smf_pkg::FIFO_CNT_BITS'(smf_pkg::FIFO_DEPTH)))
      else $error("result queue overflow");

   // a ranked transaction shows up on the response side
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      (issue && !rsp_tvalid) |=> rsp_tvalid)
      else $error("ranked result not presented");
`endif

endmodule

FILE: verif/sliding_window_median_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_median_tb
// Self-checking bench for the running median filter. A behavioural window
// model predicts value, slot and tag of the median for every accepted
// request; responses are checked in order against it. Directed cases cover
// sample extremes, ties, odd/even and extreme widths and retained slots,
// followed by random traffic under several idle/stall profiles and back
// pressure.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 80;
   localparam int REPORT_LIMIT   = 10;
   localparam int RESULT_BITS    = $bits(smf_pkg::result_type);

   // dut ports
   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              csr_we     = 1'b0;
   logic [smf_pkg::CSR_BITS-1:0]      csr_wdata  = '0;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   // sample[31:0], tag[39:32]
   logic [smf_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // median_value[31:0], median_slot[35:32], median_tag[43:36], zero[47:44]
   logic [smf_pkg::RSP_DATA_BITS-1:0] rsp_tdata;

   // window model
   logic signed [smf_pkg::SAMPLE_FIELD_BITS-1:0] win_sample [smf_pkg::MAX_WIDTH_DEF];
   logic [smf_pkg::TAG_BITS-1:0]                 win_tag    [smf_pkg::MAX_WIDTH_DEF];
   int unsigned                                  win_ptr;
   logic [smf_pkg::CSR_BITS-1:0]                 width_reg;

   smf_pkg::result_type expected_medians [$];

   // traffic shaping
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic hold_request   = 1'b0;
   int   hold_left      = 0;

   int mismatch_count = 0;
   int idle_cycles    = 0;

   sliding_window_median i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   always #5 clock = ~clock;

   // window model: write new sample, rank the window, pick the middle rank
   function automatic smf_pkg::result_type predict_median(input logic signed [31:0] s,
                                                          input logic [7:0] t);
      int unsigned         w;
      int unsigned         slot;
      int unsigned         mid;
      int unsigned         found;
      bit                  seen;
      int unsigned         rank [smf_pkg::MAX_WIDTH_DEF];
      smf_pkg::result_type r;
      w = int'(width_reg) | 1;
      if (w > smf_pkg::MAX_WIDTH_DEF)
         w = (smf_pkg::MAX_WIDTH_DEF % 2 == 1) ?
             smf_pkg::MAX_WIDTH_DEF : smf_pkg::MAX_WIDTH_DEF - 1;
      slot = (win_ptr < w) ? win_ptr : 0;
      win_sample[slot] = s;
      win_tag[slot]    = t;
      win_ptr = (slot + 1 >= w) ? 0 : slot + 1;
      for (int i = 0; i < w; i++)
         rank[i] = 0;
      // ties go to the lower slot
      for (int i = 0; i + 1 < w; i++) begin
         for (int j = i + 1; j < w; j++) begin
            if (win_sample[i] >= win_sample[j])
               rank[i]++;
            else
               rank[j]++;
         end
      end
      mid   = w / 2;
      found = 0;
      seen  = 1'b0;
      for (int i = 0; i < w; i++) begin
         if (!seen && rank[i] == mid) begin
            found = i;
            seen  = 1'b1;
         end
      end
      r.median_value = win_sample[found];
      r.median_slot  = smf_pkg::SLOT_FIELD_BITS'(found);
      r.median_tag   = win_tag[found];
      return r;
   endfunction

   // wait until every outstanding response has been received
   task automatic wait_drained();
      while (expected_medians.size() != 0)
         @(posedge clock);
   endtask

   // width write while the filter is idle; also restarts the pointer
   task automatic write_window_width(input logic [smf_pkg::CSR_BITS-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      width_reg = value;
      win_ptr   = 0;
   endtask

   // offer one request and hold it until accepted, then maybe go idle
   task automatic send_sample(input logic signed [31:0] s, input logic [7:0] t);
      req_tvalid <= 1'b1;
      req_tdata  <= {t, s};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      expected_medians.push_back(predict_median(s, t));
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // random sample: extremes, a narrow band for ties, or anything
   function automatic logic [31:0] random_sample();
      logic [31:0] extremes [4];
      extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
      case ($urandom_range(9))
         0, 1:    return extremes[$urandom_range(3)];
         2, 3, 4: return 32'($urandom_range(7)) - 32'd3;
         default: return $urandom;
      endcase
   endfunction

   // default width, zero-filled window and sample extremes
   task automatic test_reset_window();
      send_sample(32'h7fff_ffff, 8'hff);
      send_sample(32'h8000_0000, 8'h00);
      send_sample(32'hffff_ffff, 8'h5a);
      send_sample(32'h0000_0000, 8'ha5);
      send_sample(32'h0000_0001, 8'h01);
      send_sample(32'h7fff_ffff, 8'h80);
      req_tvalid <= 1'b0;
   endtask

   // even width rounds up; equal samples ordered by slot
   task automatic test_equal_samples();
      write_window_width(4'd2);
      send_sample(32'd7, 8'h01);
      send_sample(32'd7, 8'h02);
      send_sample(32'd7, 8'h03);
      send_sample(32'd7, 8'h04);
      req_tvalid <= 1'b0;
   endtask

   // smallest and largest widths
   task automatic test_width_extremes();
      write_window_width(4'd0);
      send_sample(32'h1234_5678, 8'h11);
      send_sample(32'h8000_0000, 8'h22);
      req_tvalid <= 1'b0;
      write_window_width(4'd15);
      send_sample(32'h7fff_ffff, 8'hf0);
      send_sample(32'h8000_0000, 8'h0f);
      send_sample(32'hffff_ffff, 8'hff);
      send_sample(32'h0000_0001, 8'h00);
      send_sample(32'h7fff_fffe, 8'h55);
      send_sample(32'h8000_0001, 8'haa);
      req_tvalid <= 1'b0;
   endtask

   // slots outside a narrow window keep their contents
   task automatic test_slot_retention();
      write_window_width(4'd1);
      send_sample(32'hdead_beef, 8'h3c);
      req_tvalid <= 1'b0;
      write_window_width(4'd14);
      send_sample(32'h0000_0010, 8'hc3);
      send_sample(32'hffff_fff0, 8'h99);
      req_tvalid <= 1'b0;
   endtask

   // receiver holds off while requests keep coming, filling the filter
   task automatic test_back_pressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b1;
      for (int n = 0; n < 40; n++)
         send_sample(random_sample(), 8'($urandom));
      req_tvalid <= 1'b0;
      wait_drained();
   endtask

   // random traffic in chunks, a new width between chunks
   task automatic test_random_traffic(input int items, input int send_pct,
                                      input int recv_pct,
                                      input logic [smf_pkg::CSR_BITS-1:0] first_width);
      int sent;
      int chunk;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      sent = 0;
      write_window_width(first_width);
      while (sent < items) begin
         if (sent != 0)
            write_window_width(smf_pkg::CSR_BITS'($urandom_range(15)));
         chunk = $urandom_range(30, 80);
         for (int n = 0; n < chunk && sent < items; n++) begin
            send_sample(random_sample(), 8'($urandom));
            sent++;
         end
         req_tvalid <= 1'b0;
      end
   endtask

   // receiver readiness, with a long counted hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      smf_pkg::result_type got;
      smf_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = smf_pkg::result_type'(rsp_tdata[RESULT_BITS-1:0]);
         if (expected_medians.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected response: value %0d slot %0d tag 0x%02h",
                        $signed(got.median_value), got.median_slot, got.median_tag);
         end else begin
            want = expected_medians.pop_front();
            if (got !== want ||
                rsp_tdata[smf_pkg::RSP_DATA_BITS-1 -: smf_pkg::RSP_PAD_BITS] !== '0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $write("median error: exp value %0d slot %0d tag 0x%02h, ",
                         $signed(want.median_value), want.median_slot, want.median_tag);
                  $display("got value %0d slot %0d tag 0x%02h pad 0x%0h",
                           $signed(got.median_value), got.median_slot, got.median_tag,
                           rsp_tdata[smf_pkg::RSP_DATA_BITS-1 -: smf_pkg::RSP_PAD_BITS]);
               end
            end
         end
      end
   end

   // watchdog: cycles with no transaction of any kind
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // test sequence
   initial begin
      for (int i = 0; i < smf_pkg::MAX_WIDTH_DEF; i++) begin
         win_sample[i] = '0;
         win_tag[i]    = '0;
      end
      win_ptr   = 0;
      width_reg = smf_pkg::WIDTH_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_window();
      test_equal_samples();
      test_width_extremes();
      test_slot_retention();
      test_back_pressure();
      test_random_traffic(340, 0, 0, 4'd0);
      test_random_traffic(340, 88, 0, 4'd15);
      test_random_traffic(340, 0, 88, 4'd1);
      test_random_traffic(340, 9, 9, 4'd14);

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/smf_pkg.sv
hw/rtl/smf_window.sv
hw/rtl/smf_rank.sv
hw/rtl/smf_fifo.sv
hw/rtl/sliding_window_median.sv
verif/sliding_window_median_tb.sv
